// ----- design/bounded_deque_with_remove_top_macros.svh -----
// assertion macros used by the checker file
// no dependencies; expects clk and arst_n in the scope of use
`ifndef BOUNDED_DEQUE_WITH_REMOVE_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_REMOVE_TOP_MACROS_SVH

// same-cycle implication, idle during reset
`define BDQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, idle during reset
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/bdq_pkg.sv -----
// shared constants, types and operation codes for the bounded deque
// no dependencies
package bdq_pkg;

	localparam int DEPTH      = 16;
	localparam int VALUE_BITS = 32;
	// the handle port is 32 bits, so stored entries never need more
	localparam int ENTRY_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int CNT_BITS   = $clog2(DEPTH + 1);
	localparam int IDX_BITS   = $clog2(DEPTH);

	typedef logic [ENTRY_BITS-1:0] entry_t;
	typedef logic [CNT_BITS-1:0]   count_t;
	typedef logic [IDX_BITS-1:0]   index_t;

	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [2:0] KIND_POP_BACK   = 3'd3;
	localparam logic [2:0] KIND_PEEK_FRONT = 3'd4;
	localparam logic [2:0] KIND_PEEK_BACK  = 3'd5;
	localparam logic [2:0] KIND_REMOVE     = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// broadcast to every cell of the row
	typedef struct packed {
		logic   push_front;
		logic   push_back;
		logic   pop_front;
		logic   remove;
		entry_t key;
	} cell_cmd_t;

endpackage

// ----- design/bounded_deque_with_remove_top.sv -----
// each result, with its status and occupancy, is registered straight from the accepted input
// throughput: one operation per cycle while the input is not stalled; the cell row matches and shifts on acceptance
// stall on the input follows only a held result the output side has not taken
// reset clears the entry count and the output valid; entry contents stay undefined
// top level of the bounded deque; uses bdq_pkg and bdq_cell
module bounded_deque_with_remove_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_value,
	output logic [1:0]  status,
	output logic [4:0]  occupancy
);

	bdq_pkg::count_t    count_q;
	bdq_pkg::count_t    count_next;
	logic               out_valid_q;
	bdq_pkg::entry_t    result_q;
	logic [1:0]         status_q;
	bdq_pkg::count_t    occ_q;

	logic               accept;
	logic               full;
	logic               empty;
	bdq_pkg::cell_cmd_t cmd;
	bdq_pkg::entry_t    cell_data [bdq_pkg::DEPTH];
	logic [bdq_pkg::DEPTH-1:0] occ;
	logic [bdq_pkg::DEPTH-1:0] tail;
	logic [bdq_pkg::DEPTH:0]   hit;
	bdq_pkg::index_t    back_idx;
	bdq_pkg::entry_t    res_next;
	logic [1:0]         st_next;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == bdq_pkg::count_t'(bdq_pkg::DEPTH));
	assign empty    = (count_q == '0);
	assign back_idx = bdq_pkg::IDX_BITS'(count_q - 1'b1);

	always_comb begin
		cmd.key        = value[bdq_pkg::ENTRY_BITS-1:0];
		cmd.push_front = accept && (kind == bdq_pkg::KIND_PUSH_FRONT) && !full;
		cmd.push_back  = accept && (kind == bdq_pkg::KIND_PUSH_BACK) && !full;
		cmd.pop_front  = accept && (kind == bdq_pkg::KIND_POP_FRONT) && !empty;
		cmd.remove     = accept && (kind == bdq_pkg::KIND_REMOVE);
	end

	assign hit[0] = 1'b0;

	for (genvar i = 0; i < bdq_pkg::DEPTH; i++) begin : g_cell
		bdq_pkg::entry_t prev_d;
		bdq_pkg::entry_t next_d;

		assign occ[i]  = (bdq_pkg::CNT_BITS'(i) < count_q);
		assign tail[i] = (bdq_pkg::CNT_BITS'(i) == count_q);

		if (i == 0) begin : g_head
			assign prev_d = cmd.key;
		end else begin : g_mid
			assign prev_d = cell_data[i-1];
		end

		if (i == bdq_pkg::DEPTH - 1) begin : g_last
			assign next_d = cell_data[i];
		end else begin : g_inner
			assign next_d = cell_data[i+1];
		end

		bdq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occupied  (occ[i]),
			.tail      (tail[i]),
			.prev_data (prev_d),
			.next_data (next_d),
			.hit_in    (hit[i]),
			.data      (cell_data[i]),
			.hit_out   (hit[i+1])
		);
	end

	always_comb begin
		res_next   = '0;
		st_next    = bdq_pkg::ST_OK;
		count_next = count_q;
		case (kind)
			bdq_pkg::KIND_PUSH_FRONT, bdq_pkg::KIND_PUSH_BACK: begin
				if (full) begin
					st_next = bdq_pkg::ST_FULL;
				end else begin
					count_next = bdq_pkg::count_t'(count_q + 1'b1);
				end
			end
			bdq_pkg::KIND_POP_FRONT, bdq_pkg::KIND_POP_BACK,
			bdq_pkg::KIND_PEEK_FRONT, bdq_pkg::KIND_PEEK_BACK: begin
				if (empty) begin
					st_next = bdq_pkg::ST_EMPTY;
				end else begin
					if (kind inside {bdq_pkg::KIND_POP_FRONT, bdq_pkg::KIND_PEEK_FRONT}) begin
						res_next = cell_data[0];
					end else begin
						res_next = cell_data[back_idx];
					end
					if (kind inside {bdq_pkg::KIND_POP_FRONT, bdq_pkg::KIND_POP_BACK}) begin
						count_next = bdq_pkg::count_t'(count_q - 1'b1);
					end
				end
			end
			bdq_pkg::KIND_REMOVE: begin
				if (hit[bdq_pkg::DEPTH]) begin
					count_next = bdq_pkg::count_t'(count_q - 1'b1);
				end else begin
					st_next = bdq_pkg::ST_EMPTY;
				end
			end
			default: begin
				st_next = bdq_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			count_q     <= count_next;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= res_next;
			status_q <= st_next;
			occ_q    <= count_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = 32'(result_q);
	assign status       = status_q;
	assign occupancy    = 5'(occ_q);

endmodule

// ----- design/bdq_cell.sv -----
// one slot of the deque row: holds an entry, matches it against the key
// and takes data from either neighbor or from the key; uses bdq_pkg
module bdq_cell (
	input  logic                clk,
	input  bdq_pkg::cell_cmd_t  cmd,
	input  logic                occupied,
	input  logic                tail,
	input  bdq_pkg::entry_t     prev_data,
	input  bdq_pkg::entry_t     next_data,
	input  logic                hit_in,
	output bdq_pkg::entry_t     data,
	output logic                hit_out
);

	bdq_pkg::entry_t data_q;
	logic            match;

	assign match   = occupied && (data_q == cmd.key);
	// a hit at or ahead of this slot makes it take the entry behind it, closing the gap
	assign hit_out = hit_in | match;
	assign data    = data_q;

	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			data_q <= prev_data;
		end else if (cmd.push_back && tail) begin
			data_q <= cmd.key;
		end else if (cmd.pop_front || (cmd.remove && hit_out)) begin
			data_q <= next_data;
		end
	end

endmodule

// ----- design/bdq_checker.sv -----
// port-level checks for the bounded deque, bound to the top level
// uses bdq_pkg and the macros header
`include "bounded_deque_with_remove_top_macros.svh"

module bdq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result_value,
	input logic [1:0]  status,
	input logic [4:0]  occupancy
);

	`BDQ_ASSERT_NOW(a_occ_bound,
		out_valid, occupancy <= 5'(bdq_pkg::DEPTH), "occupancy above depth")
	`BDQ_ASSERT_NOW(a_full_only_when_full,
		out_valid && status == bdq_pkg::ST_FULL,
		occupancy == 5'(bdq_pkg::DEPTH), "full status below depth")
	`BDQ_ASSERT_NOW(a_empty_zero_value,
		out_valid && status == bdq_pkg::ST_EMPTY,
		result_value == '0, "nonzero value with empty status")
	`BDQ_ASSERT_NEXT(a_out_hold,
		out_valid && out_stall,
		out_valid && $stable(result_value) && $stable(status) && $stable(occupancy),
		"stalled result changed")

endmodule

bind bounded_deque_with_remove_top bdq_checker u_bdq_checker (.*);

// ----- test/tb_bounded_deque_with_remove_top.sv -----
// testbench for bounded_deque_with_remove_top: directed and random deque operations
// predicts every result in-line and checks the output stream; depends on bdq_pkg and the rtl
`timescale 1ns / 1ps

module tb_bounded_deque_with_remove_top;

	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam int RANDOM_OPS   = 1950;
	localparam int TAIL_OPS     = 150;
	localparam int LONG_HOLD    = 80;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
	} deque_op_t;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
		logic [4:0]  occupancy;
	} deque_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  kind = '0;
	logic [31:0] value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] result_value;
	logic [1:0]  status;
	logic [4:0]  occupancy;

	deque_op_t     op_queue[$];
	deque_result_t expected_results[$];
	logic [31:0]   model_entries[$];
	deque_op_t     next_op;
	deque_result_t got;
	deque_result_t want;
	int            error_count = 0;
	int            accepted_count = 0;
	int            cycle_count = 0;
	int            gap_left = 0;
	int            hold_left = 0;
	logic          long_hold_done = 1'b0;

	bounded_deque_with_remove_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_value(result_value),
		.status(status),
		.occupancy(occupancy)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// applies one operation to the model deque and returns the expected result
	function automatic deque_result_t apply_deque_op(input logic [2:0] op, input logic [31:0] v);
		deque_result_t r;
		logic          found;
		r.value  = '0;
		r.status = bdq_pkg::ST_OK;
		found    = 1'b0;
		case (op)
			bdq_pkg::KIND_PUSH_FRONT, bdq_pkg::KIND_PUSH_BACK: begin
				if (model_entries.size() >= bdq_pkg::DEPTH)
					r.status = bdq_pkg::ST_FULL;
				else if (op == bdq_pkg::KIND_PUSH_FRONT)
					model_entries.push_front(v);
				else
					model_entries.push_back(v);
			end
			bdq_pkg::KIND_POP_FRONT, bdq_pkg::KIND_POP_BACK,
			bdq_pkg::KIND_PEEK_FRONT, bdq_pkg::KIND_PEEK_BACK: begin
				if (model_entries.size() == 0)
					r.status = bdq_pkg::ST_EMPTY;
				else if (op == bdq_pkg::KIND_POP_FRONT)
					r.value = model_entries.pop_front();
				else if (op == bdq_pkg::KIND_POP_BACK)
					r.value = model_entries.pop_back();
				else if (op == bdq_pkg::KIND_PEEK_FRONT)
					r.value = model_entries[0];
				else
					r.value = model_entries[model_entries.size() - 1];
			end
			bdq_pkg::KIND_REMOVE: begin
				r.status = bdq_pkg::ST_EMPTY;
				for (int i = 0; i < model_entries.size() && !found; i++) begin
					if (model_entries[i] == v) begin
						model_entries.delete(i);
						r.status = bdq_pkg::ST_OK;
						found = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.occupancy = 5'(model_entries.size());
		return r;
	endfunction

	task automatic add_op(input logic [2:0] k, input logic [31:0] v);
		deque_op_t o;
		o.kind  = k;
		o.value = v;
		op_queue.push_back(o);
	endtask

	// sender: offers queued operations with random gaps, none near the end
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= '0;
			value <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(apply_deque_op(kind, value));
				accepted_count <= accepted_count + 1;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (op_queue.size() == 0) begin
					in_valid <= 1'b0;
				end else if (op_queue.size() > TAIL_OPS && $urandom_range(0, 7) == 0) begin
					gap_left <= $urandom_range(0, 16);
					in_valid <= 1'b0;
				end else begin
					next_op = op_queue.pop_front();
					in_valid <= 1'b1;
					kind <= next_op.kind;
					value <= next_op.value;
				end
			end
		end
	end

	// receiver: random stall bursts plus one long hold-off so the input backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!long_hold_done && accepted_count >= 40) begin
			hold_left <= LONG_HOLD - 1;
			long_hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else if (op_queue.size() > TAIL_OPS && $urandom_range(0, 5) == 0) begin
			hold_left <= $urandom_range(0, 16);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// checks each result transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got.value     = result_value;
			got.status    = status;
			got.occupancy = occupancy;
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: value %h status %0d occupancy %0d",
					got.value, got.status, got.occupancy);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.value !== want.value) begin
					$error("result_value: expected %h, got %h", want.value, got.value);
					error_count++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					error_count++;
				end
				if (got.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_bounded_deque_with_remove_top: done, errors");
			$finish;
		end
	end

	initial begin
		logic [31:0] handle_pool[8];
		logic [2:0]  k;
		logic [31:0] v;
		int          mode;
		int          roll;
		int          push_lim;
		int          pop_lim;
		handle_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
			32'h1234_5678, 32'hDEAD_BEEF, 32'h5555_5555, 32'hAAAA_AAAA};

		// empty deque: pops, peeks and removes all report empty
		add_op(bdq_pkg::KIND_PEEK_FRONT, 32'h0);
		add_op(bdq_pkg::KIND_POP_BACK, 32'hFFFF_FFFF);
		add_op(bdq_pkg::KIND_REMOVE, 32'h5);
		// a stored zero handle still reads back as ok
		add_op(bdq_pkg::KIND_PUSH_BACK, 32'h0);
		add_op(bdq_pkg::KIND_PEEK_FRONT, 32'h0);
		add_op(bdq_pkg::KIND_PUSH_FRONT, 32'hFFFF_FFFF);
		add_op(bdq_pkg::KIND_PEEK_BACK, 32'h0);
		// duplicates: remove takes the one nearest the front
		add_op(bdq_pkg::KIND_PUSH_BACK, 32'h5);
		add_op(bdq_pkg::KIND_PUSH_FRONT, 32'h5);
		add_op(bdq_pkg::KIND_REMOVE, 32'h5);
		add_op(bdq_pkg::KIND_REMOVE, 32'h0001_2345);
		add_op(KIND_UNUSED, 32'hFFFF_FFFF);
		// fill to the top, then pushes at both ends bounce off
		for (int i = 0; i < 13; i++)
			add_op((i % 2) ? bdq_pkg::KIND_PUSH_FRONT : bdq_pkg::KIND_PUSH_BACK,
				32'h1000_0000 + i);
		add_op(bdq_pkg::KIND_PUSH_FRONT, 32'hFFFF_FFFF);
		add_op(bdq_pkg::KIND_PUSH_BACK, 32'h0);
		add_op(bdq_pkg::KIND_POP_FRONT, 32'h0);
		add_op(bdq_pkg::KIND_POP_BACK, 32'h0);

		// random part in blocks that lean toward filling, draining or neither
		mode = 2;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % 30 == 0)
				mode = $urandom_range(0, 2);
			roll = $urandom_range(0, 99);
			push_lim = (mode == 0) ? 60 : (mode == 1) ? 20 : 35;
			pop_lim = push_lim + ((mode == 1) ? 45 : 25);
			if (roll < push_lim)
				k = (roll % 2) ? bdq_pkg::KIND_PUSH_BACK : bdq_pkg::KIND_PUSH_FRONT;
			else if (roll < pop_lim)
				k = (roll % 2) ? bdq_pkg::KIND_POP_BACK : bdq_pkg::KIND_POP_FRONT;
			else if (roll < pop_lim + 12)
				k = (roll % 2) ? bdq_pkg::KIND_PEEK_BACK : bdq_pkg::KIND_PEEK_FRONT;
			else if (roll < 98)
				k = bdq_pkg::KIND_REMOVE;
			else
				k = KIND_UNUSED;
			// mostly a small pool so removes find matches
			v = ($urandom_range(0, 3) != 0) ? handle_pool[$urandom_range(0, 7)] : $urandom;
			add_op(k, v);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (op_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (error_count == 0)
			$display("tb_bounded_deque_with_remove_top: done, clean");
		else
			$display("tb_bounded_deque_with_remove_top: done, errors");
		$finish;
	end

endmodule
